FILE: hw/rtl/word_lz_decompressor_defines.svh
// Assertion macros shared by the decompressor RTL.
// No dependencies; included by the top level only.
`ifndef WORD_LZ_DECOMPRESSOR_DEFINES_SVH
`define WORD_LZ_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WLZD_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("wlzd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define WLZD_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("wlzd assertion failed");

`endif

FILE: hw/rtl/wlzd_pkg.sv
// Shared types and constants for the word LZ decompressor.
// No dependencies; imported by every module of the block.
package wlzd_pkg;

   localparam int BUF_WORDS = 512;
   localparam int ADDR_W    = $clog2(BUF_WORDS);
   localparam int CNT_W     = ADDR_W + 1;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_BODY  = 2'd1;
   localparam logic [1:0] ACT_DRAIN = 2'd2;
   localparam logic [1:0] ACT_TAIL  = 2'd3;

   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_TAIL      = 4'd1;
   localparam logic [3:0] ERR_SHORT     = 4'd2;
   localparam logic [3:0] ERR_LONG      = 4'd3;
   localparam logic [3:0] ERR_LIT_OVER  = 4'd4;
   localparam logic [3:0] ERR_OUT_OVER  = 4'd5;
   localparam logic [3:0] ERR_OFFSET    = 4'd6;
   localparam logic [3:0] ERR_FINAL_LEN = 4'd7;
   localparam logic [3:0] ERR_MISUSE    = 4'd8;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_CTRL   = 3'd1,
      PH_LIT0   = 3'd2,
      PH_MATCH0 = 3'd3,
      PH_LIT1   = 3'd4,
      PH_MATCH1 = 3'd5,
      PH_TAIL   = 3'd6
   } phase_type;

   typedef struct packed {
      logic is_start;
      logic is_body;
      logic is_drain;
      logic is_tail;
   } kind_type;

   typedef struct packed {
      kind_type     kind;
      logic [63:0]  data;
      logic [15:0]  clen;
      logic [15:0]  dlen;
   } item_type;

endpackage

FILE: hw/rtl/wlzd_front.sv
// Front end: accepts input items, decodes the action and queues them.
// Depends on wlzd_pkg.
module wlzd_front import wlzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_data_word,
   input  logic [15:0] req_compressed_length,
   input  logic [15:0] req_decompressed_length,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type   slot_ff [2];
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push;

   always_comb begin
      new_item.kind.is_start = (req_action == ACT_START);
      new_item.kind.is_body  = (req_action == ACT_BODY);
      new_item.kind.is_drain = (req_action == ACT_DRAIN);
      new_item.kind.is_tail  = (req_action == ACT_TAIL);
      new_item.data = req_data_word;
      new_item.clen = req_compressed_length;
      new_item.dlen = req_decompressed_length;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[head_ff];

   always_comb begin
      head_in  = head_ff ^ (q_pop && q_valid);
      tail_in  = tail_ff ^ push;
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= new_item;
      end
   end

endmodule

FILE: hw/rtl/wlzd_back.sv
// Back end: stream state, history store and the registered result stage.
// Depends on wlzd_pkg.
module wlzd_back import wlzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        safe_checks,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_word,
   output logic [3:0]  rsp_out_bytes,
   output logic        rsp_match_pending,
   output logic        rsp_done_res,
   output logic [3:0]  rsp_error_code
);

   phase_type          phase_ff, phase_in;
   logic [7:0]         run_ff, run_in;
   logic [CNT_W-1:0]   src_ff, src_in;
   logic [CNT_W-1:0]   outw_ff, outw_in;
   logic [12:0]        inl_ff, inl_in;
   logic [63:0]        ctrl_ff, ctrl_in;
   logic [15:0]        exp_ff, exp_in;
   logic [3:0]         errl_ff, errl_in;
   logic [2:0]         tail_ff, tail_in;

   logic               rsp_valid_ff;
   logic [63:0]        rsp_word_ff, rsp_word_in;
   logic [3:0]         rsp_bytes_ff, rsp_bytes_in;
   logic               rsp_pend_ff, rsp_pend_in;
   logic               rsp_done_ff, rsp_done_in;
   logic [3:0]         rsp_err_ff, rsp_err_in;

   logic [63:0]        hist_mem [BUF_WORDS];
   logic [63:0]        rd_data_ff;
   logic               byp_ff;
   logic [63:0]        byp_data_ff;
   logic [63:0]        hist_word;
   logic               we;
   logic [63:0]        wdata;

   logic               fire;
   logic               do_settle;
   logic               settling;
   logic [15:0]        body;
   logic [15:0]        off;
   logic [7:0]         cnt;
   logic [9:0]         need;

   assign fire      = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop     = fire;
   assign hist_word = byp_ff ? byp_data_ff : rd_data_ff;

   always_comb begin
      phase_in     = phase_ff;
      run_in       = run_ff;
      src_in       = src_ff;
      outw_in      = outw_ff;
      inl_in       = inl_ff;
      ctrl_in      = ctrl_ff;
      exp_in       = exp_ff;
      errl_in      = errl_ff;
      tail_in      = tail_ff;
      rsp_word_in  = 64'd0;
      rsp_bytes_in = 4'd0;
      rsp_done_in  = 1'b0;
      rsp_err_in   = ERR_NONE;
      we           = 1'b0;
      wdata        = q_item.data;
      do_settle    = 1'b0;
      settling     = 1'b0;
      body         = q_item.clen - 16'd2;
      off          = 16'd0;
      cnt          = 8'd0;
      need         = 10'({2'b0, q_item.data[7:0]}) + 10'({2'b0, q_item.data[15:8]})
                   + 10'({2'b0, q_item.data[39:32]}) + 10'({2'b0, q_item.data[47:40]});

      if (fire) begin
         if (q_item.kind.is_start) begin
            outw_in = '0;
            ctrl_in = 64'd0;
            run_in  = 8'd0;
            src_in  = '0;
            errl_in = ERR_NONE;
            exp_in  = q_item.dlen;
            inl_in  = body[15:3];
            tail_in = body[2:0];
            phase_in = (body[15:3] != 13'd0) ? PH_CTRL : PH_TAIL;
            if (safe_checks) begin
               priority if (body[2:0] != q_item.dlen[2:0]) begin
                  errl_in = ERR_TAIL;
               end else if (q_item.clen < 16'd2 || body[15:3] <= 13'd1) begin
                  errl_in = ERR_SHORT;
               end else if (17'(q_item.dlen) > 17'(BUF_WORDS * 8)) begin
                  errl_in = ERR_LONG;
               end else begin
                  errl_in = ERR_NONE;
               end
               if (errl_in != ERR_NONE) begin
                  phase_in = PH_IDLE;
                  run_in   = 8'd0;
               end
            end
         end else if (errl_ff != ERR_NONE) begin
            // The latched code is reported below.
         end else if (q_item.kind.is_body && phase_ff == PH_CTRL) begin
            if (inl_ff != 13'd0) begin
               inl_in = inl_ff - 13'd1;
            end
            ctrl_in = q_item.data;
            if (safe_checks && (13'({5'b0, q_item.data[7:0]}) + 13'({5'b0, q_item.data[39:32]})
                                > inl_in)) begin
               errl_in  = ERR_LIT_OVER;
               phase_in = PH_IDLE;
               run_in   = 8'd0;
            end else if (safe_checks && (13'(outw_ff) + 13'(need) > exp_ff[15:3])) begin
               errl_in  = ERR_OUT_OVER;
               phase_in = PH_IDLE;
               run_in   = 8'd0;
            end else begin
               run_in    = q_item.data[7:0];
               phase_in  = PH_LIT0;
               do_settle = 1'b1;
            end
         end else if (q_item.kind.is_body && (phase_ff == PH_LIT0 || phase_ff == PH_LIT1)) begin
            if (inl_ff != 13'd0) begin
               inl_in = inl_ff - 13'd1;
            end
            if (outw_ff >= CNT_W'(BUF_WORDS)) begin
               errl_in  = ERR_OUT_OVER;
               phase_in = PH_IDLE;
               run_in   = 8'd0;
            end else begin
               we           = 1'b1;
               wdata        = q_item.data;
               outw_in      = outw_ff + 1'b1;
               rsp_word_in  = q_item.data;
               rsp_bytes_in = 4'd8;
               run_in       = run_ff - 8'd1;
               do_settle    = 1'b1;
            end
         end else if (q_item.kind.is_drain
                      && (phase_ff == PH_MATCH0 || phase_ff == PH_MATCH1)) begin
            if (outw_ff >= CNT_W'(BUF_WORDS)) begin
               errl_in  = ERR_OUT_OVER;
               phase_in = PH_IDLE;
               run_in   = 8'd0;
            end else begin
               we           = 1'b1;
               wdata        = hist_word;
               outw_in      = outw_ff + 1'b1;
               rsp_word_in  = hist_word;
               rsp_bytes_in = 4'd8;
               src_in       = src_ff + 1'b1;
               run_in       = run_ff - 8'd1;
               do_settle    = 1'b1;
            end
         end else if (q_item.kind.is_tail && phase_ff == PH_TAIL) begin
            if (safe_checks && ({3'b0, outw_ff, tail_ff} != exp_ff)) begin
               errl_in  = ERR_FINAL_LEN;
               phase_in = PH_IDLE;
               run_in   = 8'd0;
            end else begin
               for (int i = 0; i < 8; i++) begin
                  rsp_word_in[8*i +: 8] = (3'(i) < tail_ff) ? q_item.data[8*i +: 8] : 8'd0;
               end
               rsp_bytes_in = {1'b0, tail_ff};
               rsp_done_in  = 1'b1;
               phase_in     = PH_IDLE;
            end
         end else begin
            rsp_err_in = ERR_MISUSE;
         end
      end

      // Walk through groups whose remaining counts are already zero.
      settling = do_settle;
      for (int s = 0; s < 4; s++) begin
         if (settling) begin
            unique case (phase_in)
               PH_LIT0, PH_LIT1: begin
                  if (run_in != 8'd0) begin
                     settling = 1'b0;
                  end else begin
                     off = (phase_in == PH_LIT1) ? ctrl_in[63:48] : ctrl_in[31:16];
                     cnt = (phase_in == PH_LIT1) ? ctrl_in[47:40] : ctrl_in[15:8];
                     if ((safe_checks && off > 16'(outw_in))
                         || (cnt != 8'd0 && (off == 16'd0 || off > 16'(outw_in)))) begin
                        errl_in  = ERR_OFFSET;
                        phase_in = PH_IDLE;
                        run_in   = 8'd0;
                        settling = 1'b0;
                     end else begin
                        src_in   = outw_in - off[CNT_W-1:0];
                        run_in   = cnt;
                        phase_in = (phase_in == PH_LIT1) ? PH_MATCH1 : PH_MATCH0;
                     end
                  end
               end
               PH_MATCH0: begin
                  if (run_in != 8'd0) begin
                     settling = 1'b0;
                  end else begin
                     run_in   = ctrl_in[39:32];
                     phase_in = PH_LIT1;
                  end
               end
               PH_MATCH1: begin
                  if (run_in == 8'd0) begin
                     phase_in = (inl_in != 13'd0) ? PH_CTRL : PH_TAIL;
                  end
                  settling = 1'b0;
               end
               default: begin
                  settling = 1'b0;
               end
            endcase
         end
      end

      rsp_pend_in = (errl_in == ERR_NONE)
                 && (phase_in == PH_MATCH0 || phase_in == PH_MATCH1);
      if (errl_in != ERR_NONE) begin
         rsp_err_in   = errl_in;
         rsp_word_in  = 64'd0;
         rsp_bytes_in = 4'd0;
         rsp_done_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         run_ff       <= 8'd0;
         src_ff       <= '0;
         outw_ff      <= '0;
         inl_ff       <= 13'd0;
         ctrl_ff      <= 64'd0;
         exp_ff       <= 16'd0;
         errl_ff      <= ERR_NONE;
         tail_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         src_ff   <= src_in;
         outw_ff  <= outw_in;
         inl_ff   <= inl_in;
         ctrl_ff  <= ctrl_in;
         exp_ff   <= exp_in;
         errl_ff  <= errl_in;
         tail_ff  <= tail_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff  <= rsp_word_in;
         rsp_bytes_ff <= rsp_bytes_in;
         rsp_pend_ff  <= rsp_pend_in;
         rsp_done_ff  <= rsp_done_in;
         rsp_err_ff   <= rsp_err_in;
      end
   end

   // The read address is the next match source, so the word is ready for
   // the next drain; a write to that same address this cycle is forwarded.
   always_ff @(posedge clock) begin
      if (we) begin
         hist_mem[outw_ff[ADDR_W-1:0]] <= wdata;
      end
      rd_data_ff  <= hist_mem[src_in[ADDR_W-1:0]];
      byp_ff      <= we && (outw_ff[ADDR_W-1:0] == src_in[ADDR_W-1:0]);
      byp_data_ff <= wdata;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_word      = rsp_word_ff;
   assign rsp_out_bytes     = rsp_bytes_ff;
   assign rsp_match_pending = rsp_pend_ff;
   assign rsp_done_res      = rsp_done_ff;
   assign rsp_error_code    = rsp_err_ff;

endmodule

FILE: hw/rtl/word_lz_decompressor.sv
// Word LZ decompressor. Every item (start, body word, drain, tail) produces
// exactly one result, and the block sustains one item per clock cycle while
// results are taken: a two-item input queue feeds the decoder, whose history
// store has one write and one registered read port, with the next match
// source read ahead and same-address writes forwarded. Results sit in an
// output register; a new item is decoded only once it is empty or its result
// is taken. The history store holds 512 words and needs no clearing after
// reset. The user must write safe_checks through the csr port only while the
// block is idle; the block itself does not enforce this.
`include "word_lz_decompressor_defines.svh"
module word_lz_decompressor import wlzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_data_word,
   input  logic [15:0] req_compressed_length,
   input  logic [15:0] req_decompressed_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_word,
   output logic [3:0]  rsp_out_bytes,
   output logic        rsp_match_pending,
   output logic        rsp_done_res,
   output logic [3:0]  rsp_error_code
);

   logic     safe_ff;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         safe_ff <= 1'b1;
      end else if (csr_valid) begin
         safe_ff <= csr_data;
      end
   end

   wlzd_front u_front (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_action              (req_action),
      .req_data_word           (req_data_word),
      .req_compressed_length   (req_compressed_length),
      .req_decompressed_length (req_decompressed_length),
      .q_valid                 (q_valid),
      .q_item                  (q_item),
      .q_pop                   (q_pop)
   );

   wlzd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .safe_checks       (safe_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_word      (rsp_out_word),
      .rsp_out_bytes     (rsp_out_bytes),
      .rsp_match_pending (rsp_match_pending),
      .rsp_done_res      (rsp_done_res),
      .rsp_error_code    (rsp_error_code)
   );

   `WLZD_ASSERT_IMPL(a_done_clean, clock, reset, rsp_valid && rsp_done_res, rsp_error_code == ERR_NONE && !rsp_match_pending)
   `WLZD_ASSERT_IMPL(a_err_no_data, clock, reset, rsp_valid && rsp_error_code != ERR_NONE && rsp_error_code != ERR_MISUSE, rsp_out_bytes == 4'd0 && !rsp_match_pending)
   `WLZD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_word))

endmodule

FILE: test/wlzd_checker.sv
`timescale 1ns / 1ps
// Result checker for the word LZ decompressor: watches the csr, req and rsp channels,
// keeps its own copy of the decoder state and compares every result in order.
// Depends on wlzd_pkg for action codes, error codes and phase names.
module wlzd_checker import wlzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_data_word,
   input  logic [15:0] req_compressed_length,
   input  logic [15:0] req_decompressed_length,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_out_word,
   input  logic [3:0]  rsp_out_bytes,
   input  logic        rsp_match_pending,
   input  logic        rsp_done_res,
   input  logic [3:0]  rsp_error_code,
   output int          fail_count,
   output int          pending_count
);

   typedef struct {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        pending;
      logic        done;
      logic [3:0]  code;
   } result_type;

   result_type  expected_q[$];
   int          nfail;
   logic        safe;
   logic [63:0] hist [BUF_WORDS];
   int unsigned outw, inleft, runl, msrc, expb, tailb;
   logic [3:0]  errl;
   phase_type   ph;
   logic [63:0] ctrl;

   function automatic int unsigned cbyte(int k);
      return ctrl[8*k +: 8];
   endfunction

   task automatic latch_error(logic [3:0] code);
      errl = code;
      ph = PH_IDLE;
      runl = 0;
   endtask

   task automatic open_match(int g);
      int unsigned off, cnt;
      off = cbyte(4*g + 2) | (cbyte(4*g + 3) << 8);
      cnt = cbyte(4*g + 1);
      if ((safe && off > outw) || (cnt != 0 && (off == 0 || off > outw))) begin
         latch_error(ERR_OFFSET);
      end else begin
         msrc = outw - off;
         runl = cnt;
         ph = (g != 0) ? PH_MATCH1 : PH_MATCH0;
      end
   endtask

   // Walks past empty literal and match runs until something is owed.
   task automatic advance();
      bit busy;
      busy = 1;
      while (busy) begin
         if (ph == PH_LIT0 || ph == PH_LIT1) begin
            if (runl != 0) busy = 0;
            else open_match(ph == PH_LIT1 ? 1 : 0);
         end else if (ph == PH_MATCH0) begin
            if (runl != 0) busy = 0;
            else begin
               runl = cbyte(4);
               ph = PH_LIT1;
            end
         end else if (ph == PH_MATCH1) begin
            if (runl == 0) ph = (inleft != 0) ? PH_CTRL : PH_TAIL;
            busy = 0;
         end else begin
            busy = 0;
         end
      end
   endtask

   task automatic store_word(logic [63:0] w, output bit ok);
      ok = 0;
      if (outw >= BUF_WORDS) begin
         latch_error(ERR_OUT_OVER);
      end else begin
         hist[outw] = w;
         outw++;
         ok = 1;
      end
   endtask

   task automatic decode_item();
      result_type  r;
      int unsigned body, l0, l1, need;
      logic [63:0] w;
      bit          ok;
      r = '{64'd0, 4'd0, 1'b0, 1'b0, ERR_NONE};
      if (req_action == ACT_START) begin
         body = 16'(req_compressed_length - 16'd2);
         outw = 0;
         ctrl = '0;
         runl = 0;
         msrc = 0;
         errl = ERR_NONE;
         expb = req_decompressed_length;
         inleft = body >> 3;
         tailb = body & 7;
         ph = (inleft != 0) ? PH_CTRL : PH_TAIL;
         if (safe) begin
            if (tailb != (req_decompressed_length & 7)) latch_error(ERR_TAIL);
            else if (req_compressed_length < 2 || inleft <= 1) latch_error(ERR_SHORT);
            else if (req_decompressed_length > BUF_WORDS * 8) latch_error(ERR_LONG);
         end
      end else if (errl != ERR_NONE) begin
      end else if (req_action == ACT_BODY && ph == PH_CTRL) begin
         if (inleft != 0) inleft--;
         ctrl = req_data_word;
         l0 = cbyte(0);
         l1 = cbyte(4);
         need = l0 + cbyte(1) + l1 + cbyte(5);
         if (safe && l0 + l1 > inleft) latch_error(ERR_LIT_OVER);
         else if (safe && outw + need > (expb >> 3)) latch_error(ERR_OUT_OVER);
         else begin
            runl = l0;
            ph = PH_LIT0;
            advance();
         end
      end else if (req_action == ACT_BODY && (ph == PH_LIT0 || ph == PH_LIT1)) begin
         if (inleft != 0) inleft--;
         store_word(req_data_word, ok);
         if (ok) begin
            r.word = req_data_word;
            r.nbytes = 4'd8;
            runl--;
            advance();
         end
      end else if (req_action == ACT_DRAIN && (ph == PH_MATCH0 || ph == PH_MATCH1)) begin
         w = (msrc < BUF_WORDS) ? hist[msrc] : 64'd0;
         store_word(w, ok);
         if (ok) begin
            r.word = w;
            r.nbytes = 4'd8;
            msrc++;
            runl--;
            advance();
         end
      end else if (req_action == ACT_TAIL && ph == PH_TAIL) begin
         if (safe && outw * 8 + tailb != expb) begin
            latch_error(ERR_FINAL_LEN);
         end else begin
            r.word = (tailb == 0) ? 64'd0 : req_data_word & ((64'd1 << (8 * tailb)) - 64'd1);
            r.nbytes = 4'(tailb);
            r.done = 1'b1;
            ph = PH_IDLE;
         end
      end else begin
         r.code = ERR_MISUSE;
      end
      if (errl != ERR_NONE) begin
         r = '{64'd0, 4'd0, 1'b0, 1'b0, errl};
      end
      r.pending = (errl == ERR_NONE && (ph == PH_MATCH0 || ph == PH_MATCH1));
      expected_q.push_back(r);
   endtask

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h", field, got, want);
      nfail++;
   endtask

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         safe = 1'b1;
         outw = 0;
         inleft = 0;
         runl = 0;
         msrc = 0;
         expb = 0;
         tailb = 0;
         errl = ERR_NONE;
         ph = PH_IDLE;
         ctrl = '0;
         nfail = 0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) safe = csr_data;
         if (req_valid && req_ready) decode_item();
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected result", rsp_out_word, 64'd0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_out_word !== e.word) report("out_word", rsp_out_word, e.word);
               if (rsp_out_bytes !== e.nbytes) report("out_bytes", rsp_out_bytes, e.nbytes);
               if (rsp_match_pending !== e.pending)
                  report("match_pending", rsp_match_pending, e.pending);
               if (rsp_done_res !== e.done) report("done_res", rsp_done_res, e.done);
               if (rsp_error_code !== e.code) report("error_code", rsp_error_code, e.code);
            end
         end
      end
      fail_count <= nfail;
      pending_count <= expected_q.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the decompressor testbench: drives well-formed and broken streams with
// random gaps and stalls under both check settings. Depends on wlzd_pkg, the
// block word_lz_decompressor and the wlzd_checker module.
module tb_top;
   import wlzd_pkg::*;

   typedef struct {
      logic [1:0]  act;
      logic [63:0] data;
      logic [15:0] clen;
      logic [15:0] dlen;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_START;
   logic [63:0] req_data_word = '0;
   logic [15:0] req_compressed_length = '0;
   logic [15:0] req_decompressed_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_out_word;
   logic [3:0]  rsp_out_bytes;
   logic        rsp_match_pending;
   logic        rsp_done_res;
   logic [3:0]  rsp_error_code;
   int          fail_count;
   int          pending_count;

   stim_type pend[$];
   int       sent_count = 0;
   int       stream_count = 0;
   bit       long_stall_done = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   word_lz_decompressor uut (.*);
   wlzd_checker chk (.*);

   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", pending_count);
      $display("tb_top failed");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] rand_len();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] ctrl_word(int l0, int m0, int o0, int l1, int m1, int o1);
      return {16'(o1), 8'(m1), 8'(l1), 16'(o0), 8'(m0), 8'(l0)};
   endfunction

   function automatic int run_count();
      return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 12);
   endfunction

   task automatic queue_item(logic [1:0] act, logic [63:0] data, logic [15:0] cl,
                             logic [15:0] dl);
      pend.push_back('{act, data, cl, dl});
   endtask

   task automatic send_pending();
      stim_type s;
      int       g;
      while (pend.size() != 0) begin
         s = pend.pop_front();
         g = gap_len();
         if (g != 0) begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_action <= s.act;
         req_data_word <= s.data;
         req_compressed_length <= s.clen;
         req_decompressed_length <= s.dlen;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         sent_count++;
      end
   endtask

   // Lets every expected result arrive, plus a margin for the pipeline.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_checks(logic v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Builds one stream with random content. Offsets stay inside the output
   // produced so far, bar a rare random second offset; a big stream overruns the
   // history store and is cut off soon after: later items only repeat the error.
   task automatic make_stream(bit big);
      int        nctrl, outw, body, tl, wa, wb, idx;
      int        l0, m0, o0, l1, m1, o1;
      stim_type  items[$];
      nctrl = big ? 3 : $urandom_range(1, 3);
      outw = 0;
      body = 0;
      for (int c = 0; c < nctrl; c++) begin
         l0 = big ? 255 : run_count();
         wa = outw + l0;
         m0 = (wa == 0) ? 0 : run_count();
         o0 = (m0 != 0) ? $urandom_range(1, wa) : $urandom_range(0, wa);
         l1 = big ? 255 : run_count();
         wb = wa + m0 + l1;
         m1 = (wb == 0) ? 0 : run_count();
         o1 = (m1 != 0) ? $urandom_range(1, wb) : $urandom_range(0, wb);
         if ($urandom_range(0, 15) == 0) o1 = $urandom_range(0, 65535);
         if (big) begin
            m0 = 0;
            m1 = 0;
         end
         items.push_back('{ACT_BODY, ctrl_word(l0, m0, o0, l1, m1, o1), rand_len(), rand_len()});
         repeat (l0) items.push_back('{ACT_BODY, {$urandom, $urandom}, rand_len(), rand_len()});
         repeat (m0) items.push_back('{ACT_DRAIN, {$urandom, $urandom}, rand_len(), rand_len()});
         repeat (l1) items.push_back('{ACT_BODY, {$urandom, $urandom}, rand_len(), rand_len()});
         repeat (m1) items.push_back('{ACT_DRAIN, {$urandom, $urandom}, rand_len(), rand_len()});
         body += 1 + l0 + l1;
         outw = wb + m1;
      end
      tl = $urandom_range(0, 7);
      items.push_back('{ACT_TAIL, {$urandom, $urandom}, rand_len(), rand_len()});
      items.push_front('{ACT_START, {$urandom, $urandom}, 16'(8 * body + tl + 2),
                         16'(8 * outw + tl)});
      if (big) begin
         while (items.size() > 520) items.pop_back();
      end
      if ($urandom_range(0, 9) == 0) begin
         idx = $urandom_range(0, items.size() - 1);
         items[idx] = '{2'($urandom), {$urandom, $urandom}, rand_len(), rand_len()};
      end
      if ($urandom_range(0, 19) == 0) items.pop_back();
      pend = {pend, items};
      stream_count++;
   endtask

   initial begin
      int unsigned stop_at;
      forever begin
         @(posedge clock);
         if (!reset) break;
      end
      forever begin
         if (!long_stall_done && sent_count > 300) begin
            long_stall_done = 1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         stop_at = gap_len();
         if (stop_at != 0) begin
            rsp_ready <= 1'b0;
            repeat (stop_at) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin
      int phase_end;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_checks(1'b1);

      // Misuse before any start, then the length checks at their extremes.
      queue_item(ACT_BODY, '1, 16'hFFFF, 16'hFFFF);
      queue_item(ACT_DRAIN, '0, 16'd0, 16'd0);
      queue_item(ACT_TAIL, '1, 16'd0, 16'd0);
      queue_item(ACT_START, '0, 16'd0, 16'hFFFF);
      queue_item(ACT_BODY, '1, 16'd0, 16'd0);
      queue_item(ACT_START, '0, 16'd1, 16'd7);
      queue_item(ACT_START, '0, 16'hFFFF, 16'hFFFF);
      queue_item(ACT_START, '0, 16'hFFFF, 16'hFFFD);
      queue_item(ACT_START, '0, 16'd2, 16'd0);
      // A match count with offset zero.
      queue_item(ACT_START, '0, 16'd25, 16'd23);
      queue_item(ACT_BODY, ctrl_word(1, 1, 0, 0, 0, 0), '0, '0);
      queue_item(ACT_BODY, 64'h0123_4567_89AB_CDEF, '0, '0);
      queue_item(ACT_DRAIN, '0, '0, '0);
      // One literal repeated three times by an overlapping match, then a full tail.
      queue_item(ACT_START, '0, 16'd25, 16'd39);
      queue_item(ACT_BODY, ctrl_word(1, 3, 1, 0, 0, 0), '0, '0);
      queue_item(ACT_BODY, 64'hFEDC_BA98_7654_3210, '0, '0);
      repeat (3) queue_item(ACT_DRAIN, '0, '0, '0);
      queue_item(ACT_TAIL, '1, '0, '0);
      queue_item(ACT_TAIL, '1, '0, '0);
      send_pending();
      drain_block();

      for (int p = 0; p < 4; p++) begin
         phase_end = sent_count + 200;
         write_checks(p[0] ? 1'b1 : 1'b0);
         if (p == 0) begin
            queue_item(ACT_START, '0, 16'd2, 16'd0);
            queue_item(ACT_TAIL, '1, '0, '0);
            make_stream(1'b1);
         end
         while (sent_count < phase_end) begin
            make_stream(1'b0);
            if ($urandom_range(0, 7) == 0) begin
               queue_item(2'($urandom), {$urandom, $urandom}, rand_len(), rand_len());
            end
            send_pending();
         end
         send_pending();
         drain_block();
      end

      repeat (20) @(posedge clock);
      $display("%0d items in %0d streams, with checks on and off, long stall included",
               sent_count, stream_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
